### rtl/pwlr_pkg.sv
// Package for the parity word link receiver: link codes, result record and shared types.
`timescale 1ns / 1ps

package pwlr_pkg;

    // Link words
    localparam logic [15:0] START_WORD   = 16'hCF96;
    localparam logic [15:0] END_WORD     = 16'hAF96;
    localparam logic [15:0] REPLY_START_WORD  = 16'hFC00;
    localparam logic [15:0] REPLY_END_WORD    = 16'hFA00;
    localparam logic [15:0] REPLY_GOOD_WORD   = 16'h9600;
    localparam logic [15:0] REPLY_RESEND_WORD = 16'h9F00;
    localparam logic [6:0]  CHECK_TAG    = 7'h6F;   // word[15:9] of a check word
    localparam logic [7:0]  CHECK_BITS   = 8'h22;
    localparam logic [15:0] END_MARK     = 16'hFFFF;

    // Reset values of the window registers and the frame pointer
    localparam logic [15:0] WINDOW_LOW_RST  = 16'hB800;
    localparam logic [15:0] WINDOW_HIGH_RST = 16'hFBFF;
    localparam logic [15:0] LAST_ADDR_RST   = 16'hFC00;

    // Byte targets, word[13:12]
    typedef enum logic [1:0] {
        TGT_ADDR_HIGH = 2'd0,
        TGT_ADDR_LOW  = 2'd1,
        TGT_DATA_HIGH = 2'd2,
        TGT_DATA_LOW  = 2'd3
    } byte_tgt_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WINDOW_LOW  = 1'b0,
        CFG_WINDOW_HIGH = 1'b1
    } cfg_idx_t;

    // Reply kinds carried through the queue
    typedef enum logic [1:0] {
        REPLY_START  = 2'd0,
        REPLY_GOOD   = 2'd1,
        REPLY_RESEND = 2'd2,
        REPLY_END    = 2'd3
    } reply_code_t;

    typedef struct packed {
        logic [15:0] low;
        logic [15:0] high;
    } window_t;

    typedef struct packed {
        reply_code_t code;
        logic        wr;
        logic [15:0] addr;
        logic [15:0] data;
        logic        done;
    } rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Even parity into bit 8, or-ed with any bit already there
    function automatic logic [8:0] parity9(input logic [8:0] n);
        parity9 = {(^n[7:0]) | n[8], n[7:0]};
    endfunction

    function automatic logic [15:0] reply_word_of(input reply_code_t c);
        logic [15:0] w;
        unique case (c)
            REPLY_START:  w = REPLY_START_WORD;
            REPLY_GOOD:   w = REPLY_GOOD_WORD;
            REPLY_RESEND: w = REPLY_RESEND_WORD;
            REPLY_END:    w = REPLY_END_WORD;
            default:      w = REPLY_RESEND_WORD;
        endcase
        reply_word_of = w;
    endfunction

endpackage

### rtl/parity_word_link_receiver_unit.sv
// Top level of the parity word link receiver: window registers, front end, queue, result stage.
// A result is offered only after its sample transfer has passed through a queue entry and then
// the output register.
// Throughput: one sample per cycle; sample_ready drops only when the record queue
// (QUEUE_DEPTH entries) is full because results are not being taken.
// Samples that produce no reply never enter the queue.
// Reset: asynchronous active-low rst_n clears the session, byte registers and queue;
// window registers return to 0xB800 and 0xFBFF; no clearing pass is needed.
`timescale 1ns / 1ps

module parity_word_link_receiver_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        sample_valid,
    output logic        sample_ready,
    input  logic [15:0] port_word,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        reply_valid,
    output logic [15:0] reply_word,
    output logic        write_valid,
    output logic [15:0] write_address,
    output logic [15:0] write_data,
    output logic        session_done
);
    import pwlr_pkg::*;

    window_t win_reg;
    qstat_t  qstat;
    logic    push;
    logic    pop;
    rec_t    push_rec;
    rec_t    head_rec;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.low  <= WINDOW_LOW_RST;
            win_reg.high <= WINDOW_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WINDOW_LOW:  win_reg.low  <= cfg_data;
                CFG_WINDOW_HIGH: win_reg.high <= cfg_data;
                default:         win_reg.high <= cfg_data;
            endcase
        end
    end

    pwlr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .port_word    (port_word),
        .win          (win_reg),
        .qstat        (qstat),
        .push         (push),
        .push_rec     (push_rec)
    );

    pwlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .qstat    (qstat)
    );

    pwlr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .qstat         (qstat),
        .head_rec      (head_rec),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .reply_valid   (reply_valid),
        .reply_word    (reply_word),
        .write_valid   (write_valid),
        .write_address (write_address),
        .write_data    (write_data),
        .session_done  (session_done)
    );

endmodule

### rtl/pwlr_front.sv
// Front end: takes port samples, tracks session and byte registers, queues reply records.
`timescale 1ns / 1ps

module pwlr_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            sample_valid,
    output logic            sample_ready,
    input  logic [15:0]     port_word,
    input  pwlr_pkg::window_t win,
    input  pwlr_pkg::qstat_t  qstat,
    output logic            push,
    output pwlr_pkg::rec_t  push_rec
);
    import pwlr_pkg::*;

    logic        active_reg, active_next;
    logic [15:0] prev_reg, prev_next;
    logic [7:0]  ah_reg, ah_next;
    logic [7:0]  al_reg, al_next;
    logic [7:0]  dh_reg, dh_next;
    logic [7:0]  dl_reg, dl_next;
    logic [3:0]  mask_reg, mask_next;
    logic [15:0] last_reg, last_next;

    logic        accept;
    logic        is_start, is_end, is_check;
    logic [8:0]  k;
    logic        check_ok;
    logic [15:0] frame_addr;
    logic        in_window;
    logic        byte_ok;
    logic [15:0] span;
    logic [15:0] sweep_end;
    logic [15:0] last_inc;
    logic [3:0]  mask_tmp;

    assign sample_ready = !qstat.full;
    assign accept       = sample_valid && sample_ready;

    // Word classification
    assign is_start = (port_word == START_WORD);
    assign is_end   = (port_word == END_WORD);
    assign is_check = (port_word[15:9] == CHECK_TAG);

    // Check parity source bits and frame address
    assign k = {1'b0, 8'h00} | (9'((ah_reg & CHECK_BITS)) << 3)
             | (9'((al_reg & CHECK_BITS)) << 2)
             | (9'((dh_reg & CHECK_BITS)) << 1)
             | 9'((dl_reg & CHECK_BITS));
    assign check_ok   = (port_word[8:0] == parity9(k)) && (mask_reg == 4'hF);
    assign frame_addr = {ah_reg, al_reg};
    assign in_window  = (frame_addr >= win.low) && (frame_addr <= win.high);
    assign byte_ok    = ((^port_word[7:0]) == port_word[8]);

    // End of the block-wise sweep over the window, modulo 2^16
    assign span      = win.high - win.low;
    assign sweep_end = (win.low <= win.high) ? (win.low + {span[15:8] + 8'd1, 8'h00})
                                             : win.low;
    assign last_inc  = last_reg + 16'd1;

    // Next state and queued record
    always_comb
    begin
        active_next = active_reg;
        prev_next   = prev_reg;
        ah_next     = ah_reg;
        al_next     = al_reg;
        dh_next     = dh_reg;
        dl_next     = dl_reg;
        mask_next   = mask_reg;
        last_next   = last_reg;
        mask_tmp    = mask_reg;
        push        = 1'b0;
        push_rec    = '{code: REPLY_START, wr: 1'b0, addr: 16'h0, data: 16'h0, done: 1'b0};

        if (accept)
        begin
            if (!active_reg)
            begin
                if (is_start)
                begin
                    active_next = 1'b1;
                    prev_next   = port_word;
                    mask_next   = 4'h0;
                    last_next   = sweep_end;
                    push        = 1'b1;
                end
            end
            else if (port_word != prev_reg)
            begin
                prev_next = port_word;
                if (is_start)
                begin
                    push = 1'b1;
                end
                else if (is_end)
                begin
                    last_next     = last_inc;
                    active_next   = 1'b0;
                    push          = 1'b1;
                    push_rec.code = REPLY_END;
                    push_rec.wr   = 1'b1;
                    push_rec.addr = last_inc;
                    push_rec.data = END_MARK;
                    push_rec.done = 1'b1;
                end
                else
                begin
                    if (is_check)
                    begin
                        push = 1'b1;
                        if (check_ok)
                        begin
                            push_rec.code = REPLY_GOOD;
                            last_next     = frame_addr;
                            if (in_window)
                            begin
                                push_rec.wr   = 1'b1;
                                push_rec.addr = frame_addr;
                                push_rec.data = {dh_reg, dl_reg};
                            end
                        end
                        else
                        begin
                            push_rec.code = REPLY_RESEND;
                        end
                        mask_tmp = 4'h0;
                    end
                    // A check word also lands here as an address-low byte
                    if (byte_ok)
                    begin
                        unique case (byte_tgt_t'(port_word[13:12]))
                            TGT_ADDR_HIGH:
                            begin
                                ah_next     = port_word[7:0];
                                mask_tmp[0] = 1'b1;
                            end
                            TGT_ADDR_LOW:
                            begin
                                al_next     = port_word[7:0];
                                mask_tmp[1] = 1'b1;
                            end
                            TGT_DATA_HIGH:
                            begin
                                dh_next     = port_word[7:0];
                                mask_tmp[2] = 1'b1;
                            end
                            TGT_DATA_LOW:
                            begin
                                dl_next     = port_word[7:0];
                                mask_tmp[3] = 1'b1;
                            end
                            default:
                            begin
                                dl_next     = port_word[7:0];
                                mask_tmp[3] = 1'b1;
                            end
                        endcase
                    end
                    mask_next = mask_tmp;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            prev_reg   <= 16'h0;
            ah_reg     <= 8'h0;
            al_reg     <= 8'h0;
            dh_reg     <= 8'h0;
            dl_reg     <= 8'h0;
            mask_reg   <= 4'h0;
            last_reg   <= LAST_ADDR_RST;
        end
        else
        begin
            active_reg <= active_next;
            prev_reg   <= prev_next;
            ah_reg     <= ah_next;
            al_reg     <= al_next;
            dh_reg     <= dh_next;
            dl_reg     <= dl_next;
            mask_reg   <= mask_next;
            last_reg   <= last_next;
        end
    end

`ifndef SYNTH
    // Outside a session only the start word produces a reply
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !active_reg && !is_start) |-> !push)
        else $error("reply queued outside a session");

    // The end reply closes the session
    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_rec.code == REPLY_END) |=> !active_reg)
        else $error("session still open after end reply");

    // A write is only ever queued with a good or end reply
    a_write_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_rec.wr) |-> (push_rec.code == REPLY_GOOD || push_rec.code == REPLY_END))
        else $error("write queued with wrong reply");
`endif

endmodule

### rtl/pwlr_queue.sv
// Short record queue between the front end and the result stage.
`timescale 1ns / 1ps

module pwlr_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  pwlr_pkg::rec_t   push_rec,
    input  logic             pop,
    output pwlr_pkg::rec_t   head_rec,
    output pwlr_pkg::qstat_t qstat
);
    import pwlr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.empty = (count_reg == '0);
    assign head_rec    = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!qstat.full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("queue underflow");
`endif

endmodule

### rtl/pwlr_back.sv
// Result stage: pulls records from the queue into the output register and decodes them.
`timescale 1ns / 1ps

module pwlr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  pwlr_pkg::qstat_t qstat,
    input  pwlr_pkg::rec_t   head_rec,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output logic             reply_valid,
    output logic [15:0]      reply_word,
    output logic             write_valid,
    output logic [15:0]      write_address,
    output logic [15:0]      write_data,
    output logic             session_done
);
    import pwlr_pkg::*;

    logic valid_reg;
    rec_t out_reg;

    // Load when the output register is free or being drained this cycle
    assign pop = !qstat.empty && (!valid_reg || result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= head_rec;
        end
    end

    // Output decode
    assign result_valid  = valid_reg;
    assign reply_valid   = 1'b1;
    assign reply_word    = reply_word_of(out_reg.code);
    assign write_valid   = out_reg.wr;
    assign write_address = out_reg.addr;
    assign write_data    = out_reg.data;
    assign session_done  = out_reg.done;

`ifndef SYNTH
    // A held result is not overwritten by a queue pop
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !result_ready) |-> !pop)
        else $error("pending result overwritten");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the parity word link receiver: stimulus, reply predictor and checker.
`timescale 1ns / 1ps

module testbench;
    import pwlr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PERCENT = 11;

    // One reply record as the block presents it
    typedef struct packed {
        logic        reply_valid;
        logic [15:0] reply_word;
        logic        write_valid;
        logic [15:0] write_address;
        logic [15:0] write_data;
        logic        session_done;
    } link_reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    cfg_idx_t    cfg_index = CFG_WINDOW_LOW;
    logic [15:0] cfg_data = 16'h0000;
    logic        sample_valid = 1'b0;
    logic        sample_ready;
    logic [15:0] port_word = 16'h0000;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        reply_valid;
    logic [15:0] reply_word;
    logic        write_valid;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic        session_done;

    // Samples waiting to be driven, and replies the link should produce
    logic [15:0] port_samples [$];
    link_reply_t awaited_replies [$];

    // Receiver state as predicted from the accepted samples
    window_t     window = {WINDOW_LOW_RST, WINDOW_HIGH_RST};
    logic        in_session = 1'b0;
    logic [15:0] prev_word = 16'h0000;
    logic [7:0]  addr_hi = 8'h00;
    logic [7:0]  addr_lo = 8'h00;
    logic [7:0]  data_hi = 8'h00;
    logic [7:0]  data_lo = 8'h00;
    logic [3:0]  seen_mask = 4'h0;
    logic [15:0] frame_addr = LAST_ADDR_RST;

    // Window as known to the stimulus side, for biasing addresses
    window_t     gen_window = {WINDOW_LOW_RST, WINDOW_HIGH_RST};

    bit sample_fired = 1'b0;
    bit no_idle = 1'b0;
    int queued_count = 0;
    int accepted_count = 0;
    int replies_checked = 0;
    int writes_seen = 0;
    int settings_used = 1;
    int failures = 0;
    int cycle_count = 0;

    parity_word_link_receiver_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .port_word    (port_word),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .reply_valid  (reply_valid),
        .reply_word   (reply_word),
        .write_valid  (write_valid),
        .write_address(write_address),
        .write_data   (write_data),
        .session_done (session_done)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Nine-bit value with even parity folded into bit 8
    function automatic logic [8:0] even_par9(input logic [8:0] n);
        logic [8:0] v;
        v = n;
        v[8] = n[8] | (^n[7:0]);
        return v;
    endfunction

    // Check word expected for a given set of four frame bytes
    function automatic logic [15:0] frame_check(input logic [7:0] ah, input logic [7:0] al,
                                                input logic [7:0] dh, input logic [7:0] dl);
        logic [8:0] k;
        k = (9'(ah & CHECK_BITS) << 3) | (9'(al & CHECK_BITS) << 2)
          | (9'(dh & CHECK_BITS) << 1) | 9'(dl & CHECK_BITS);
        return {CHECK_TAG, even_par9(k)};
    endfunction

    // Tagged byte word with correct parity; pad fills bits 15:14 and 11:9
    function automatic logic [15:0] byte_word(input byte_tgt_t tgt, input logic [7:0] b,
                                              input logic [4:0] pad);
        return {pad[4:3], tgt, pad[2:0], ^b, b};
    endfunction

    // Predict the reply, if any, for one accepted port sample
    task automatic receive_word(input logic [15:0] w);
        link_reply_t r;
        logic [15:0] a;
        logic [15:0] span;
        logic [7:0]  b;
        r = '0;
        if (!in_session) begin
            if (w == START_WORD) begin
                in_session = 1'b1;
                prev_word = w;
                seen_mask = 4'h0;
                span = window.high - window.low;
                if (window.low <= window.high)
                    frame_addr = window.low + {span[15:8] + 8'h01, 8'h00};
                else
                    frame_addr = window.low;
                r.reply_valid = 1'b1;
                r.reply_word = REPLY_START_WORD;
                awaited_replies.push_back(r);
            end
        end else if (w != prev_word) begin
            prev_word = w;
            if (w == START_WORD) begin
                r.reply_valid = 1'b1;
                r.reply_word = REPLY_START_WORD;
                awaited_replies.push_back(r);
            end else if (w == END_WORD) begin
                frame_addr = frame_addr + 16'h0001;
                in_session = 1'b0;
                r = {1'b1, REPLY_END_WORD, 1'b1, frame_addr, END_MARK, 1'b1};
                awaited_replies.push_back(r);
            end else begin
                // check word: verdict first, then it falls through as a byte word
                if (w[15:9] == CHECK_TAG) begin
                    r.reply_valid = 1'b1;
                    if (w == frame_check(addr_hi, addr_lo, data_hi, data_lo)
                        && seen_mask == 4'hF) begin
                        a = {addr_hi, addr_lo};
                        frame_addr = a;
                        r.reply_word = REPLY_GOOD_WORD;
                        if (a >= window.low && a <= window.high) begin
                            r.write_valid = 1'b1;
                            r.write_address = a;
                            r.write_data = {data_hi, data_lo};
                        end
                    end else begin
                        r.reply_word = REPLY_RESEND_WORD;
                    end
                    seen_mask = 4'h0;
                    awaited_replies.push_back(r);
                end
                b = w[7:0];
                if (w[8] == ^b) begin
                    case (byte_tgt_t'(w[13:12]))
                        TGT_ADDR_HIGH: begin addr_hi = b; seen_mask[0] = 1'b1; end
                        TGT_ADDR_LOW:  begin addr_lo = b; seen_mask[1] = 1'b1; end
                        TGT_DATA_HIGH: begin data_hi = b; seen_mask[2] = 1'b1; end
                        default:       begin data_lo = b; seen_mask[3] = 1'b1; end
                    endcase
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
        end
    endtask

    // Driver: new sample and ready at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n) begin
            sample_valid <= 1'b0;
            result_ready <= 1'b0;
        end else begin
            if (!sample_valid || sample_fired) begin
                if (port_samples.size() != 0
                    && (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
                    port_word <= port_samples.pop_front();
                    sample_valid <= 1'b1;
                end else begin
                    sample_valid <= 1'b0;
                end
            end
            result_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Monitor: check reply transfers, track config writes, predict from sample transfers
    always @(posedge clk)
    begin : monitor
        link_reply_t want;
        if (!rst_n) begin
            sample_fired = 1'b0;
        end else begin
            if (result_valid && result_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("reply with none expected: reply_word %h", reply_word);
                    failures++;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("reply_valid", 16'(want.reply_valid), 16'(reply_valid));
                    check_field("reply_word", want.reply_word, reply_word);
                    check_field("write_valid", 16'(want.write_valid), 16'(write_valid));
                    check_field("write_address", want.write_address, write_address);
                    check_field("write_data", want.write_data, write_data);
                    check_field("session_done", 16'(want.session_done), 16'(session_done));
                    replies_checked++;
                    if (want.write_valid)
                        writes_seen++;
                end
            end
            if (cfg_write) begin
                if (cfg_index == CFG_WINDOW_LOW)
                    window.low = cfg_data;
                else
                    window.high = cfg_data;
            end
            sample_fired = sample_valid && sample_ready;
            if (sample_fired) begin
                accepted_count++;
                receive_word(port_word);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", CYCLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_word(input logic [15:0] w);
        port_samples.push_back(w);
        queued_count++;
    endtask

    // Wait until every sample is taken and every reply has come back
    task automatic wait_drained();
        while (accepted_count != queued_count || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WINDOW_LOW;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= CFG_WINDOW_HIGH;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_write <= 1'b0;
        gen_window.low = lo;
        gen_window.high = hi;
        settings_used++;
    endtask

    // One frame of four bytes and a check word, with occasional faults
    task automatic random_frame();
        logic [15:0] addr;
        logic [15:0] data;
        logic [15:0] w;
        logic [7:0]  part [4];
        int first, step, skip, spoil, slot, pick;
        if (gen_window.low <= gen_window.high && $urandom_range(99) < 70)
            addr = 16'($urandom_range(gen_window.high, gen_window.low));
        else
            addr = 16'($urandom);
        data = 16'($urandom);
        part[0] = addr[15:8];
        part[1] = addr[7:0];
        part[2] = data[15:8];
        part[3] = data[7:0];
        first = $urandom_range(3);
        step  = $urandom_range(1) ? 1 : 3;
        skip  = ($urandom_range(99) < 6) ? int'($urandom_range(3)) : -1;
        spoil = ($urandom_range(99) < 6) ? int'($urandom_range(3)) : -1;
        for (int i = 0; i < 4; i++) begin
            slot = (first + step * i) % 4;
            if (slot != skip) begin
                w = byte_word(byte_tgt_t'(2'(slot)), part[slot], 5'($urandom));
                if (slot == spoil)
                    w[8] = ~w[8];
                push_word(w);
                // held port value, stray restart or line noise
                if ($urandom_range(99) < 4)
                    push_word(w);
                if ($urandom_range(99) < 3)
                    push_word($urandom_range(1) ? START_WORD : 16'($urandom));
            end
        end
        w = frame_check(part[0], part[1], part[2], part[3]);
        pick = $urandom_range(99);
        if (pick < 8)
            w[$urandom_range(8)] = ~w[$urandom_range(8)];
        else if (pick < 12)
            w[8:0] = 9'($urandom);
        push_word(w);
    endtask

    task automatic random_session();
        int frames;
        frames = $urandom_range(6, 1);
        // words ahead of the start are dropped by the block
        if ($urandom_range(99) < 30)
            repeat ($urandom_range(3, 1)) push_word(16'($urandom));
        push_word(START_WORD);
        repeat (frames) random_frame();
        if ($urandom_range(99) < 90)
            push_word(END_WORD);
    endtask

    task automatic run_phase(input int n);
        int target;
        target = queued_count + n;
        while (queued_count < target)
            random_session();
        wait_drained();
    endtask

    // Stimulus
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle words, start, repeats, parity fault, wrap of the end write,
        // both ends of the reset window, check word used as a byte
        push_word(16'h1234);
        push_word(END_WORD);
        push_word(START_WORD);
        push_word(START_WORD);
        push_word(byte_word(TGT_ADDR_HIGH, 8'hFF, 5'h00));
        push_word(byte_word(TGT_ADDR_HIGH, 8'h00, 5'h00) ^ 16'h0100);
        push_word(byte_word(TGT_ADDR_LOW, 8'hFF, 5'h18));
        push_word(byte_word(TGT_DATA_HIGH, 8'h00, 5'h07));
        push_word(byte_word(TGT_DATA_LOW, 8'h80, 5'h1F));
        push_word(frame_check(8'hFF, 8'hFF, 8'h00, 8'h80));
        push_word(START_WORD);
        push_word(END_WORD);
        push_word(START_WORD);
        push_word(byte_word(TGT_ADDR_HIGH, 8'hB8, 5'h00));
        push_word(byte_word(TGT_ADDR_LOW, 8'h00, 5'h00));
        push_word(byte_word(TGT_DATA_HIGH, 8'hA5, 5'h00));
        push_word(byte_word(TGT_DATA_LOW, 8'h5A, 5'h00));
        push_word(frame_check(8'hB8, 8'h00, 8'hA5, 8'h5A));
        push_word(byte_word(TGT_ADDR_HIGH, 8'hFB, 5'h00));
        push_word(byte_word(TGT_ADDR_LOW, 8'hFF, 5'h00));
        push_word(byte_word(TGT_DATA_HIGH, 8'h12, 5'h00));
        push_word(byte_word(TGT_DATA_LOW, 8'h34, 5'h00));
        push_word(frame_check(8'hFB, 8'hFF, 8'h12, 8'h34));
        push_word({CHECK_TAG, 9'h1FF});
        push_word(END_WORD);
        wait_drained();

        // Random sessions under a range of windows
        set_window(16'h0000, 16'hFFFF);
        run_phase(130);
        set_window(16'hFFFF, 16'h0000);
        run_phase(110);
        no_idle = 1'b1;
        set_window(16'hFF00, 16'hFFFF);
        run_phase(130);
        no_idle = 1'b0;
        set_window(16'h1234, 16'h1234);
        run_phase(110);
        set_window(16'($urandom), 16'($urandom));
        run_phase(160);
        set_window(WINDOW_LOW_RST, WINDOW_HIGH_RST);
        run_phase(160);

        failures += awaited_replies.size();
        $display("Covered %0d port samples over %0d window settings", accepted_count,
                 settings_used);
        $display("Checked %0d reply transfers, %0d of them with storage writes",
                 replies_checked, writes_seen);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
